[design/ppmd_pkg.sv]
// ppmd_pkg: shared types, widths and constants for the ppm channel decoder
// used by ppmd_front, ppmd_queue, ppmd_back and ppm_channel_decoder_unit
`default_nettype none

package ppmd_pkg;

    // field widths
    localparam int TIME_W    = 10;
    localparam int IN_CFG_W  = 10;
    localparam int OUT_CFG_W = 12;
    localparam int CHAN_W    = 3;
    localparam int VALUE_W   = 19;
    localparam int IVAL_W    = 11;  // signed interval between captures
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    // stream data widths in bits
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // divider sizing: magnitude of (d - in_low) * (out_high - out_low)
    localparam int QUO_W = 23;
    localparam int DIV_W = 10;
    localparam int CNT_W = $clog2(QUO_W + 1);

    // defaults
    localparam int CAPTURES_PER_FRAME_DEF = 6;
    localparam int TIMER_WRAP_DEF         = 1023;
    localparam int QUEUE_DEPTH_DEF        = 2;

    // register reset values
    localparam logic [IN_CFG_W-1:0]  IN_LOW_RST   = 10'd63;
    localparam logic [IN_CFG_W-1:0]  IN_HIGH_RST  = 10'd125;
    localparam logic [OUT_CFG_W-1:0] OUT_LOW_RST  = 12'd1000;
    localparam logic [OUT_CFG_W-1:0] OUT_HIGH_RST = 12'd2000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 2'd3;

    // configuration seen by the back end
    typedef struct packed {
        logic [IN_CFG_W-1:0]  in_low;
        logic [IN_CFG_W-1:0]  in_high;
        logic [OUT_CFG_W-1:0] out_low;
        logic [OUT_CFG_W-1:0] out_high;
    } ppmd_cfg_t;

    // one classified capture waiting for the mapping unit
    typedef struct packed {
        logic [CHAN_W-1:0]        channel_index;
        logic                     frame_done;
        logic signed [IVAL_W-1:0] interval;
    } ppmd_entry_t;

endpackage

`default_nettype wire

[design/ppm_channel_decoder_unit.sv]
// ppm_channel_decoder_unit: top level of the ppm channel decoder
// instantiates ppmd_front, ppmd_queue and ppmd_back, types from ppmd_pkg
//
// Usage:
//   s_* channel: one transfer per capture time (timer value at a pulse edge).
//   m_* channel: one transfer per decoded channel: index, mapped value, and
//   tlast on the last channel of a frame. The first capture of a frame
//   gives no output transfer.
//   cfg_*: single-cycle register writes (in_low, in_high, out_low, out_high),
//   only while the block is idle.
// Path: an input transfer is queued, popped in ST_IDLE, multiplied in ST_MUL,
//   divided bit-serially in ST_DIV and loaded into the output register in ST_FIX.
// Flow: the shared divider works on one result at a time and pops the next entry
//   only once the last is loaded. The front takes captures at once while the queue
//   has room, so up to QUEUE_DEPTH results can be pending behind the divider.
// Reset: frame position and previous time clear to zero, registers return
//   to their defaults, queue and output register empty.
// Stall: a result waits in the output register until m_tready; the divider
//   then holds its result and the queue fills, after which s_tready drops.
`default_nettype none

module ppm_channel_decoder_unit #(
    parameter int CAPTURES_PER_FRAME = ppmd_pkg::CAPTURES_PER_FRAME_DEF,
    parameter int TIMER_WRAP         = ppmd_pkg::TIMER_WRAP_DEF,
    parameter int QUEUE_DEPTH        = ppmd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ppmd_pkg::S_DATA_W-1:0]     s_tdata,   // [9:0] capture_time
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ppmd_pkg::M_DATA_W-1:0]          m_tdata,   // [2:0] channel_index,
                                                              // [21:3] channel_value
    output logic                                   m_tlast,   // frame_done
    input  wire logic                              cfg_we,
    input  wire logic [ppmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ppmd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ppmd_pkg::*;

    ppmd_cfg_t   cfg_reg;
    ppmd_entry_t push_entry;
    ppmd_entry_t head;

    logic               accept;
    logic               push;
    logic               pop;
    logic               q_not_empty;
    logic               q_full;
    logic [CHAN_W-1:0]  out_channel;
    logic [VALUE_W-1:0] out_value;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_low   <= IN_LOW_RST;
            cfg_reg.in_high  <= IN_HIGH_RST;
            cfg_reg.out_low  <= OUT_LOW_RST;
            cfg_reg.out_high <= OUT_HIGH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IN_LOW:   cfg_reg.in_low   <= cfg_wdata[IN_CFG_W-1:0];
                REG_IN_HIGH:  cfg_reg.in_high  <= cfg_wdata[IN_CFG_W-1:0];
                REG_OUT_LOW:  cfg_reg.out_low  <= cfg_wdata[OUT_CFG_W-1:0];
                REG_OUT_HIGH: cfg_reg.out_high <= cfg_wdata[OUT_CFG_W-1:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // input transfer
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    ppmd_front #(
        .CAPTURES_PER_FRAME (CAPTURES_PER_FRAME),
        .TIMER_WRAP         (TIMER_WRAP)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .capture_time (s_tdata[TIME_W-1:0]),
        .push         (push),
        .entry        (push_entry)
    );

    ppmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .full       (q_full),
        .head       (head)
    );

    ppmd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (head),
        .q_pop       (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_channel (out_channel),
        .out_value   (out_value),
        .out_last    (m_tlast)
    );

    // output packing
    assign m_tdata = {{(M_DATA_W - CHAN_W - VALUE_W){1'b0}}, out_value, out_channel};

`ifndef SYNTH
    // the last channel of a frame always carries the highest index
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[CHAN_W-1:0] == CHAN_W'(CAPTURES_PER_FRAME - 1))
        else $error("frame end on wrong channel index");

    // reported channel index stays within the frame
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[CHAN_W-1:0] != '0)
                  && (m_tdata[CHAN_W-1:0] < CHAN_W'(CAPTURES_PER_FRAME)))
        else $error("channel index out of range");

    // a result leaves the output register only by a transfer
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result dropped without transfer");
`endif

endmodule

`default_nettype wire

[design/ppmd_front.sv]
// ppmd_front: accepts capture times, tracks frame position and previous time,
// and queues an entry with the interval for every capture that yields a channel
`default_nettype none

module ppmd_front #(
    parameter int CAPTURES_PER_FRAME = ppmd_pkg::CAPTURES_PER_FRAME_DEF,
    parameter int TIMER_WRAP         = ppmd_pkg::TIMER_WRAP_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [ppmd_pkg::TIME_W-1:0]   capture_time,
    output logic                               push,
    output ppmd_pkg::ppmd_entry_t              entry
);
    import ppmd_pkg::*;

    localparam logic [CHAN_W-1:0] LAST_POS = CHAN_W'(CAPTURES_PER_FRAME);
    localparam logic signed [IVAL_W:0] WRAP_VAL = (IVAL_W + 1)'(TIMER_WRAP);

    logic [CHAN_W-1:0] pos_reg, pos_next;
    logic [TIME_W-1:0] prev_reg, prev_next;

    logic [CHAN_W-1:0]        pos_inc;
    logic                     out_of_range;
    logic                     has_result;
    logic                     last;
    logic signed [IVAL_W:0]   wrap_sum;
    logic signed [IVAL_W-1:0] interval;

    // classify the capture by its place in the frame
    always_comb
    begin
        pos_inc      = pos_reg + 1'b1;
        out_of_range = (pos_reg >= LAST_POS);
        has_result   = (pos_inc > CHAN_W'(1)) || out_of_range;
        last         = (pos_inc >= LAST_POS) || out_of_range;
    end

    // interval since the previous capture, wrapping at the timer limit
    always_comb
    begin
        wrap_sum = WRAP_VAL - $signed({2'b00, prev_reg}) + $signed({2'b00, capture_time});
        if (capture_time > prev_reg)
        begin
            interval = $signed({1'b0, capture_time}) - $signed({1'b0, prev_reg});
        end
        else
        begin
            interval = wrap_sum[IVAL_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        pos_next  = pos_reg;
        prev_next = prev_reg;
        if (accept)
        begin
            prev_next = capture_time;
            pos_next  = (has_result && last) ? '0 : pos_inc;
        end
    end

    assign push                = accept && has_result;
    assign entry.channel_index = pos_inc - 1'b1;
    assign entry.frame_done    = last;
    assign entry.interval      = interval;

    // position and previous time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            prev_reg <= prev_next;
        end
    end

endmodule

`default_nettype wire

[design/ppmd_queue.sv]
// ppmd_queue: short first-in first-out queue of classified captures
// between ppmd_front and ppmd_back, entry type from ppmd_pkg
`default_nettype none

module ppmd_queue #(
    parameter int DEPTH = ppmd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  ppmd_pkg::ppmd_entry_t      push_entry,
    input  wire logic                  pop,
    output logic                       not_empty,
    output logic                       full,
    output ppmd_pkg::ppmd_entry_t      head
);
    import ppmd_pkg::*;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

    ppmd_entry_t slot_reg [DEPTH];

    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == DEPTH_CNT);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

[design/ppmd_back.sv]
// ppmd_back: maps queued intervals onto the output span with one multiply and a
// bit-serial restoring divider, and holds the result in the output register
`default_nettype none

module ppmd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  ppmd_pkg::ppmd_cfg_t                cfg,
    input  wire logic                          q_not_empty,
    input  ppmd_pkg::ppmd_entry_t              q_head,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ppmd_pkg::CHAN_W-1:0]        out_channel,
    output logic [ppmd_pkg::VALUE_W-1:0]       out_value,
    output logic                               out_last
);
    import ppmd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIX
    } state_t;

    localparam int PROD_W = 25;
    localparam int SUM_W  = QUO_W + 2;

    state_t state_reg;

    logic signed [OUT_CFG_W-1:0] diff_reg;      // d - in_low
    logic signed [OUT_CFG_W:0]   span_out_reg;
    logic signed [IVAL_W-1:0]    span_in_reg;
    logic [CHAN_W-1:0]           chan_reg;
    logic                        last_reg;
    logic                        neg_reg;
    logic                        zero_div_reg;
    logic [DIV_W-1:0]            divisor_reg;
    logic [DIV_W-1:0]            rem_reg;
    logic [QUO_W-1:0]            quo_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        out_valid_reg;
    logic [CHAN_W-1:0]           out_channel_reg;
    logic [VALUE_W-1:0]          out_value_reg;
    logic                        out_last_reg;

    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]         prod_mag;
    logic [IVAL_W-1:0]         span_in_mag;
    logic [DIV_W:0]            rem_shift;
    logic                      rem_ge;
    logic signed [QUO_W:0]     quo_signed;
    logic signed [SUM_W-1:0]   mapped;
    logic [VALUE_W-1:0]        saturated;
    logic                      fits;
    logic                      out_free;

    // product and magnitudes
    always_comb
    begin
        prod        = diff_reg * span_out_reg;
        prod_mag    = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        span_in_mag = span_in_reg[IVAL_W-1] ? IVAL_W'(-span_in_reg) : IVAL_W'(span_in_reg);
    end

    // one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[QUO_W-1]};
        rem_ge    = (rem_shift >= {1'b0, divisor_reg});
    end

    // sign, offset and saturation
    always_comb
    begin
        if (zero_div_reg)
        begin
            quo_signed = '0;
        end
        else if (neg_reg)
        begin
            quo_signed = -$signed({1'b0, quo_reg});
        end
        else
        begin
            quo_signed = $signed({1'b0, quo_reg});
        end
        mapped = SUM_W'(quo_signed) + $signed({{(SUM_W - OUT_CFG_W){1'b0}}, cfg.out_low});
        fits   = (mapped[SUM_W-1:VALUE_W-1] == '0) || (mapped[SUM_W-1:VALUE_W-1] == '1);
        if (fits)
        begin
            saturated = mapped[VALUE_W-1:0];
        end
        else if (mapped[SUM_W-1])
        begin
            saturated = {1'b1, {(VALUE_W - 1){1'b0}}};
        end
        else
        begin
            saturated = {1'b0, {(VALUE_W - 1){1'b1}}};
        end
    end

    assign out_free    = !out_valid_reg || out_ready;
    assign q_pop       = (state_reg == ST_IDLE) && q_not_empty;
    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign out_value   = out_value_reg;
    assign out_last    = out_last_reg;

    // sequencer, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            diff_reg        <= '0;
            span_out_reg    <= '0;
            span_in_reg     <= '0;
            chan_reg        <= '0;
            last_reg        <= 1'b0;
            neg_reg         <= 1'b0;
            zero_div_reg    <= 1'b0;
            divisor_reg     <= '0;
            rem_reg         <= '0;
            quo_reg         <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_channel_reg <= '0;
            out_value_reg   <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            // in ST_FIX the load below covers a transfer in the same cycle
            if (out_valid_reg && out_ready && (state_reg != ST_FIX))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        diff_reg     <= {q_head.interval[IVAL_W-1], q_head.interval}
                                        - $signed({2'b00, cfg.in_low});
                        span_out_reg <= $signed({1'b0, cfg.out_high})
                                        - $signed({1'b0, cfg.out_low});
                        span_in_reg  <= $signed({1'b0, cfg.in_high})
                                        - $signed({1'b0, cfg.in_low});
                        chan_reg     <= q_head.channel_index;
                        last_reg     <= q_head.frame_done;
                        state_reg    <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    neg_reg      <= prod[PROD_W-1] ^ span_in_reg[IVAL_W-1];
                    zero_div_reg <= (span_in_reg == '0);
                    divisor_reg  <= span_in_mag[DIV_W-1:0];
                    rem_reg      <= '0;
                    quo_reg      <= prod_mag[QUO_W-1:0];
                    cnt_reg      <= CNT_W'(QUO_W);
                    state_reg    <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (rem_ge)
                    begin
                        rem_reg <= DIV_W'(rem_shift - {1'b0, divisor_reg});
                    end
                    else
                    begin
                        rem_reg <= rem_shift[DIV_W-1:0];
                    end
                    quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_channel_reg <= chan_reg;
                        out_value_reg   <= saturated;
                        out_last_reg    <= last_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
